[hdl/invariant_mass_constraint_engine_core_assert.svh]
// assertion macros shared by the rtl
`ifndef INVARIANT_MASS_CONSTRAINT_ENGINE_CORE_ASSERT_SVH
`define INVARIANT_MASS_CONSTRAINT_ENGINE_CORE_ASSERT_SVH

// property holds at every edge outside reset
`define IMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("imc assertion failed");

// consequent holds in the cycle after the antecedent
`define IMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imc assertion failed");

`endif

[hdl/imc_pkg.sv]
package imc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 40;
  localparam int MAG_W     = 32;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DEN_W     = 3 * MAG_W;
  localparam int NUM_W     = SQ_W + 1 + 2 * FRAC_BITS;

  localparam logic [3:0] ITEM_MASS    = 4'd0;
  localparam logic [3:0] ITEM_FIRST0  = 4'd1;
  localparam logic [3:0] ITEM_FIRST3  = 4'd4;
  localparam logic [3:0] ITEM_SECOND0 = 4'd5;
  localparam logic [3:0] ITEM_LAST    = 4'd14;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_MASS   = 2'd1,
    KIND_FIRST  = 2'd2,
    KIND_SECOND = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic               second_group;
    logic               final_particle;
  } in_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic               group;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               overflow;
    logic               energy_not_positive;
    logic               run_end;
  } out_beat_t;

  // upper triangle of the hessian, row major: {row, col}
  function automatic logic [3:0] pair_rc(input logic [3:0] k);
    logic [3:0] rc;
    case (k)
      4'd0:    rc = 4'b0000;
      4'd1:    rc = 4'b0001;
      4'd2:    rc = 4'b0010;
      4'd3:    rc = 4'b0011;
      4'd4:    rc = 4'b0101;
      4'd5:    rc = 4'b0110;
      4'd6:    rc = 4'b0111;
      4'd7:    rc = 4'b1010;
      4'd8:    rc = 4'b1011;
      4'd9:    rc = 4'b1111;
      default: rc = 4'b0000;
    endcase
    return rc;
  endfunction

endpackage

[hdl/imc_mul.sv]
module imc_mul import imc_pkg::*; (
  input  logic             clk_i,
  input  logic [MAG_W-1:0] a_i,
  input  logic [MAG_W-1:0] b_i,
  output logic [SQ_W-1:0]  p_o
);

  logic [SQ_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= SQ_W'(a_i) * SQ_W'(b_i);
  end

  assign p_o = p_q;

endmodule

[hdl/imc_sqrt.sv]
module imc_sqrt import imc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SQ_W-1:0]  rad_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [MAG_W-1:0] root_o
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]  rad_q;
  logic [MAG_W:0]   rem_q;
  logic [MAG_W-1:0] root_q;
  logic [MAG_W+2:0] sh, trial, diff;
  logic             ge;

  assign sh    = {rem_q, rad_q[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = sh >= trial;
  assign diff  = sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MAG_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[MAG_W:0] : sh[MAG_W:0];
      root_q <= {root_q[MAG_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[hdl/imc_div.sv]
module imc_div import imc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [MAG_W:0]   quot_o,
  output logic             big_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [MAG_W:0]   quot_q;
  logic             big_q;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_q, num_q[NUM_W-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      big_q  <= 1'b0;
    end else if (busy_q) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quot_q <= {quot_q[MAG_W-1:0], ge};
      big_q  <= big_q | quot_q[MAG_W];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign big_o  = big_q;

endmodule

[hdl/invariant_mass_constraint_engine_core.sv]
// Invariant mass constraint engine. Particles arrive one per beat on the input channel and are
// added into four saturating sums per group in the cycle of acceptance, so non-final particles
// are taken back to back. The beat marked final starts the evaluation and holds in_stall_o high
// until the run of 31 result beats has been produced: per group the squares and the cube of
// the mass on one shared 32x32 multiplier and the bit-pair square root (32 steps), then
// the derivatives in the single restoring divider (one quotient bit per cycle over a
// 97-bit numerator).
// target_mass may be written whenever no run is in progress.
module invariant_mass_constraint_engine_core import imc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [30:0] cfg_data_i
);

`include "invariant_mass_constraint_engine_core_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SQ   = 9'b000000010,
    S_M2   = 9'b000000100,
    S_SQRT = 9'b000001000,
    S_CUBE = 9'b000010000,
    S_PREP = 9'b000100000,
    S_MULN = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_e;

  localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  state_e state_q, state_d;

  logic signed [SUM_WIDTH-1:0] sums_q [8];
  logic signed [SUM_WIDTH-1:0] sums_new [4];
  logic signed [SUM_WIDTH-1:0] sums_nx [8];
  logic signed [31:0]          in_x [4];

  logic [MAG_W-1:0] mag_q [2][4];
  logic             ng_q [2][4];
  logic             clamp_q [2];
  logic             enp_q [2];
  logic [SQ_W-1:0]  sq_q [2][4];
  logic [SQ_W-1:0]  m2_q [2];
  logic [MAG_W-1:0] m_q [2];
  logic [DEN_W-1:0] den3_q [2];
  logic [SQ_W-1:0]  p2_q, lo_q;
  logic [MAG_W-1:0] mm_hi_q;

  logic       grp_q, cons_q;
  logic [2:0] cnt_q;
  logic [3:0] idx_q;
  logic       neg_q;
  logic [31:0] res_val_q;
  logic        res_ovf_q;
  out_beat_t   out_q;
  logic        out_valid_q;
  logic [30:0] target_q;

  logic in_acc, load;
  logic [MAG_W-1:0] mul_a, mul_b, m_cur;
  logic [SQ_W-1:0]  mul_p, e2, m2_cur, m2_new, d00;
  logic             neg00;
  logic             div_start, div_busy, div_done, div_big;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [MAG_W:0]   div_quot;
  logic             sqrt_busy, sqrt_done;
  logic [MAG_W-1:0] sqrt_root;

  logic       is_mass, is_first, need_mul, is_diag, base, neg_item, div_over;
  logic [1:0] fc, pr, pc;
  logic [3:0] rc;
  logic signed [34:0] cdiff;
  logic               csat;
  logic [31:0]        div_val;
  out_beat_t          beat;

  assign in_stall_o  = state_q != S_IDLE;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign in_x[0] = in_data_i.energy;
  assign in_x[1] = in_data_i.mom_x;
  assign in_x[2] = in_data_i.mom_y;
  assign in_x[3] = in_data_i.mom_z;

  // saturating accumulation
  always_comb begin
    logic signed [SUM_WIDTH:0] wide;
    for (int c = 0; c < 4; c++) begin
      wide = $signed({sums_q[{in_data_i.second_group, 2'(c)}][SUM_WIDTH-1],
                      sums_q[{in_data_i.second_group, 2'(c)}]})
             + (SUM_WIDTH+1)'(in_x[c]);
      if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
        sums_new[c] = wide[SUM_WIDTH] ? SMIN : SMAX;
      end else begin
        sums_new[c] = wide[SUM_WIDTH-1:0];
      end
    end
    for (int k = 0; k < 8; k++) sums_nx[k] = sums_q[k];
    for (int c = 0; c < 4; c++) sums_nx[{in_data_i.second_group, 2'(c)}] = sums_new[c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) sums_q[k] <= '0;
    end else if (in_acc) begin
      if (in_data_i.final_particle) begin
        for (int k = 0; k < 8; k++) sums_q[k] <= '0;
      end else begin
        for (int c = 0; c < 4; c++) sums_q[{in_data_i.second_group, 2'(c)}] <= sums_new[c];
      end
    end
  end

  // clamp to 32 bits and split sign and magnitude
  always_ff @(posedge clk_i) begin
    logic [SUM_WIDTH-32:0] upper;
    logic                  fits;
    logic [31:0]           s32;
    logic [1:0]            clp;
    if (in_acc && in_data_i.final_particle) begin
      clp = '0;
      for (int g = 0; g < 2; g++) begin
        enp_q[g] <= sums_nx[g*4][SUM_WIDTH-1] || (sums_nx[g*4] == '0);
      end
      for (int k = 0; k < 8; k++) begin
        upper = sums_nx[k][SUM_WIDTH-1:31];
        fits  = (&upper) || !(|upper);
        s32   = fits ? sums_nx[k][31:0]
                     : (sums_nx[k][SUM_WIDTH-1] ? 32'h8000_0000 : 32'h7fff_ffff);
        ng_q[k/4][k%4]  <= s32[31];
        mag_q[k/4][k%4] <= s32[31] ? (32'd0 - s32) : s32;
        if (!fits) clp[k/4] = 1'b1;
      end
      for (int g = 0; g < 2; g++) clamp_q[g] <= clp[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  // item decode
  assign m_cur   = m_q[grp_q];
  assign e2      = sq_q[grp_q][0];
  assign m2_cur  = m2_q[grp_q];
  assign m2_new  = (e2 >= p2_q) ? (e2 - p2_q) : (p2_q - e2);
  assign neg00   = m2_cur < e2;
  assign d00     = neg00 ? (e2 - m2_cur) : (m2_cur - e2);
  assign is_mass  = idx_q == ITEM_MASS;
  assign is_first = (idx_q >= ITEM_FIRST0) && (idx_q <= ITEM_FIRST3);
  assign fc       = 2'(idx_q - ITEM_FIRST0);
  assign rc       = pair_rc(idx_q - ITEM_SECOND0);
  assign pr       = rc[3:2];
  assign pc       = rc[1:0];
  assign is_diag  = pr == pc;
  assign need_mul = !is_mass && !is_first && !is_diag;
  assign base     = clamp_q[grp_q] || (m_cur == '0);

  always_comb begin
    logic n;
    if (is_first) begin
      n = (fc == 2'd0) ? ng_q[grp_q][0] : !ng_q[grp_q][fc];
    end else if (pr == 2'd0 && pc == 2'd0) begin
      n = neg00;
    end else if (pr == 2'd0) begin
      n = ng_q[grp_q][0] != ng_q[grp_q][pc];
    end else if (is_diag) begin
      n = 1'b1;
    end else begin
      n = ng_q[grp_q][pr] == ng_q[grp_q][pc];
    end
    neg_item = n ^ grp_q;
  end

  assign cdiff = $signed({3'b000, m_q[0]}) - $signed({3'b000, m_q[1]})
               - $signed({4'b0000, target_q});
  assign csat  = !((&cdiff[34:31]) || !(|cdiff[34:31]));

  assign div_over = div_big || div_quot[MAG_W] ||
                    (neg_q ? (div_quot[31] && (div_quot[30:0] != '0)) : div_quot[31]);
  assign div_val  = div_over ? (neg_q ? 32'h8000_0000 : 32'h7fff_ffff)
                             : (neg_q ? (32'd0 - div_quot[31:0]) : div_quot[31:0]);

  // shared multiplier operands
  always_comb begin
    mul_a = mag_q[grp_q][cnt_q[1:0]];
    mul_b = mag_q[grp_q][cnt_q[1:0]];
    unique case (state_q)
      S_CUBE: begin
        case (cnt_q)
          3'd1:    mul_a = mul_p[MAG_W-1:0];
          3'd2:    mul_a = mm_hi_q;
          default: mul_a = m_cur;
        endcase
        mul_b = m_cur;
      end
      S_PREP: begin
        mul_a = mag_q[grp_q][pr];
        mul_b = mag_q[grp_q][pc];
      end
      default: ;
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = NUM_W'(mul_p) << (2 * FRAC_BITS);
    div_den   = den3_q[grp_q];
    unique case (state_q)
      S_PREP: begin
        if (!cons_q && !is_mass && !need_mul && m_cur != '0) div_start = 1'b1;
        if (is_first) begin
          div_num = NUM_W'(mag_q[grp_q][fc]) << FRAC_BITS;
          div_den = DEN_W'(m_cur);
        end else if (pr == 2'd0) begin
          div_num = NUM_W'(d00) << (2 * FRAC_BITS);
        end else begin
          div_num = NUM_W'({1'b0, m2_cur} + {1'b0, sq_q[grp_q][pr]}) << (2 * FRAC_BITS);
        end
      end
      S_MULN: div_start = 1'b1;
      default: ;
    endcase
  end

  assign load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_data_i.final_particle) state_d = S_SQ;
      S_SQ:   if (cnt_q == 3'd4) state_d = S_M2;
      S_M2:   state_d = S_SQRT;
      S_SQRT: if (sqrt_done) state_d = S_CUBE;
      S_CUBE: if (cnt_q == 3'd3) state_d = grp_q ? S_PREP : S_SQ;
      S_PREP: begin
        if (cons_q || is_mass || m_cur == '0) state_d = S_EMIT;
        else if (need_mul) state_d = S_MULN;
        else state_d = S_DIV;
      end
      S_MULN: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_EMIT;
      S_EMIT: begin
        if (load) state_d = (!cons_q && grp_q && idx_q == ITEM_LAST) ? S_IDLE : S_PREP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      cons_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          grp_q <= 1'b0;
          cnt_q <= '0;
        end
        S_SQ:   cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
        S_CUBE: begin
          cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            grp_q <= !grp_q;
            if (grp_q) begin
              cons_q <= 1'b1;
              idx_q  <= '0;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            if (cons_q) begin
              cons_q <= 1'b0;
              grp_q  <= 1'b0;
              idx_q  <= '0;
            end else if (idx_q == ITEM_LAST) begin
              grp_q <= 1'b1;
              idx_q <= '0;
            end else begin
              idx_q <= idx_q + 4'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_SQ: begin
        if (cnt_q != 3'd0) sq_q[grp_q][2'(cnt_q - 3'd1)] <= mul_p;
        if (cnt_q == 3'd1) p2_q <= '0;
        else if (cnt_q != 3'd0) p2_q <= p2_q + mul_p;
      end
      S_M2:   m2_q[grp_q] <= m2_new;
      S_SQRT: if (sqrt_done) m_q[grp_q] <= sqrt_root;
      S_CUBE: begin
        if (cnt_q == 3'd1) mm_hi_q <= mul_p[SQ_W-1:MAG_W];
        if (cnt_q == 3'd2) lo_q <= mul_p;
        if (cnt_q == 3'd3) den3_q[grp_q] <= {mul_p, {MAG_W{1'b0}}} + DEN_W'(lo_q);
      end
      S_PREP: begin
        neg_q <= neg_item;
        if (cons_q) begin
          res_val_q <= csat ? (cdiff[34] ? 32'h8000_0000 : 32'h7fff_ffff) : cdiff[31:0];
          res_ovf_q <= clamp_q[0] || clamp_q[1] || csat;
        end else if (is_mass) begin
          res_val_q <= m_cur[31] ? 32'h7fff_ffff : m_cur;
          res_ovf_q <= base || m_cur[31];
        end else begin
          res_val_q <= '0;
          res_ovf_q <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_val_q <= div_val;
          res_ovf_q <= base || div_over;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    beat = '0;
    beat.value    = res_val_q;
    beat.overflow = res_ovf_q;
    if (cons_q) begin
      beat.kind                = KIND_VALUE;
      beat.energy_not_positive = enp_q[0] || enp_q[1];
    end else begin
      beat.group               = grp_q;
      beat.energy_not_positive = enp_q[grp_q];
      beat.run_end             = grp_q && (idx_q == ITEM_LAST);
      if (is_mass) begin
        beat.kind = KIND_MASS;
      end else if (is_first) begin
        beat.kind = KIND_FIRST;
        beat.row  = fc;
      end else begin
        beat.kind = KIND_SECOND;
        beat.row  = pr;
        beat.col  = pc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= beat;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  imc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  imc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_M2),
    .rad_i   (m2_new),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  imc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .big_o   (div_big)
  );

  `IMC_ASSERT(a_div_in_div, div_busy |-> state_q == S_DIV)
  `IMC_ASSERT(a_sqrt_in_sqrt, sqrt_busy |-> state_q == S_SQRT)
  `IMC_ASSERT_NEXT(a_final_starts, in_acc && in_data_i.final_particle, state_q == S_SQ)
  `IMC_ASSERT_NEXT(a_load_shows, load, out_valid_q)

endmodule

[sim/tb.sv]
module tb;
  import imc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ACC_MAX = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_beat_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_beat_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i;

  invariant_mass_constraint_engine_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  typedef struct {
    in_beat_t beat;
    bit has_exp;
    logic signed [31:0] exp_value;
    bit exp_enp;
  } dir_row_t;

  longint sums[8];
  logic [30:0] target_mass;
  out_beat_t result_q[$];
  logic signed [31:0] last_constraint;
  bit last_enp;
  int mismatches;
  longint cycles;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [31:0] clip32(input longint v, inout bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] scaled_quot(input bit neg, input logic [127:0] num,
                                              input int shift, input logic [127:0] den,
                                              inout bit ovf);
    logic [127:0] q, lim;
    if (den == 0) begin
      ovf = 1'b1;
      return 32'h0;
    end
    q = (num << shift) / den;
    lim = neg ? 128'h80000000 : 128'h7fffffff;
    if (q > lim) begin
      ovf = 1'b1;
      return neg ? 32'h80000000 : 32'h7fffffff;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic void push_result(input kind_e kind, input bit grp, input logic [1:0] row,
                                      input logic [1:0] col, input logic [31:0] val,
                                      input bit ovf, input bit enp, input bit last);
    out_beat_t r;
    r.kind = kind;
    r.group = grp;
    r.row = row;
    r.col = col;
    r.value = val;
    r.overflow = ovf;
    r.energy_not_positive = enp;
    r.run_end = last;
    result_q.push_back(r);
  endfunction

  function automatic void evaluate_run();
    logic [63:0] mag[2][4];
    bit ng[2][4];
    bit clamp[2];
    bit enp[2];
    logic [63:0] e2[2], m2[2], m[2], p2;
    longint s;
    bit ovf, base, neg;
    logic [127:0] num, den1, den3;
    logic [31:0] v;
    for (int g = 0; g < 2; g++) begin
      p2 = 0;
      clamp[g] = 1'b0;
      enp[g] = sums[g * 4] <= 0;
      for (int c = 0; c < 4; c++) begin
        s = sums[g * 4 + c];
        v = clip32(s, clamp[g]);
        s = longint'($signed(v));
        ng[g][c] = s < 0;
        mag[g][c] = s < 0 ? -s : s;
        if (c > 0) p2 = p2 + mag[g][c] * mag[g][c];
      end
      e2[g] = mag[g][0] * mag[g][0];
      m2[g] = e2[g] >= p2 ? e2[g] - p2 : p2 - e2[g];
      m[g] = int_sqrt(m2[g]);
    end
    ovf = clamp[0] || clamp[1];
    v = clip32(longint'(m[0]) - longint'(m[1]) - longint'(target_mass), ovf);
    last_constraint = v;
    last_enp = enp[0] || enp[1];
    push_result(KIND_VALUE, 1'b0, 2'd0, 2'd0, v, ovf, enp[0] || enp[1], 1'b0);
    for (int g = 0; g < 2; g++) begin
      base = clamp[g] || m[g] == 0;
      den1 = {64'd0, m[g]};
      den3 = {64'd0, m[g]} * {64'd0, m[g]} * {64'd0, m[g]};
      ovf = base;
      v = clip32(longint'(m[g]), ovf);
      push_result(KIND_MASS, 1'(g), 2'd0, 2'd0, v, ovf, enp[g], 1'b0);
      for (int c = 0; c < 4; c++) begin
        neg = (c == 0 ? ng[g][0] : !ng[g][c]) != (g == 1);
        ovf = base;
        v = scaled_quot(neg, {64'd0, mag[g][c]}, FRAC_BITS, den1, ovf);
        push_result(KIND_FIRST, 1'(g), 2'(c), 2'd0, v, ovf, enp[g], 1'b0);
      end
      for (int r = 0; r < 4; r++) begin
        for (int c = r; c < 4; c++) begin
          if (r == 0 && c == 0) begin
            neg = m2[g] < e2[g];
            num = {64'd0, neg ? e2[g] - m2[g] : m2[g] - e2[g]};
          end else if (r == 0) begin
            num = {64'd0, mag[g][0]} * {64'd0, mag[g][c]};
            neg = ng[g][0] != ng[g][c];
          end else if (r == c) begin
            num = {64'd0, m2[g]} + {64'd0, mag[g][c]} * {64'd0, mag[g][c]};
            neg = 1'b1;
          end else begin
            num = {64'd0, mag[g][r]} * {64'd0, mag[g][c]};
            neg = ng[g][r] == ng[g][c];
          end
          if (g == 1) neg = !neg;
          ovf = base;
          v = scaled_quot(neg, num, 2 * FRAC_BITS, den3, ovf);
          push_result(KIND_SECOND, 1'(g), 2'(r), 2'(c), v, ovf, enp[g], g == 1 && r == 3);
        end
      end
    end
    for (int c = 0; c < 8; c++) sums[c] = 0;
  endfunction

  function automatic void take_particle(input in_beat_t b);
    longint x;
    int base_i;
    logic [31:0] f[4];
    f[0] = b.energy;
    f[1] = b.mom_x;
    f[2] = b.mom_y;
    f[3] = b.mom_z;
    base_i = b.second_group ? 4 : 0;
    for (int c = 0; c < 4; c++) begin
      x = longint'($signed(f[c]));
      if (x > 0 && sums[base_i + c] > ACC_MAX - x) sums[base_i + c] = ACC_MAX;
      else if (x < 0 && sums[base_i + c] < ACC_MIN - x) sums[base_i + c] = ACC_MIN;
      else sums[base_i + c] = sums[base_i + c] + x;
    end
    if (b.final_particle) evaluate_run();
  endfunction

  function automatic void note_mismatch(input out_beat_t exp_r, input out_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected k%0d g%0d r%0d c%0d v%h o%0d e%0d l%0d, got k%0d g%0d r%0d c%0d v%h o%0d e%0d l%0d",
               exp_r.kind, exp_r.group, exp_r.row, exp_r.col, exp_r.value, exp_r.overflow,
               exp_r.energy_not_positive, exp_r.run_end, got.kind, got.group, got.row,
               got.col, got.value, got.overflow, got.energy_not_positive, got.run_end);
  endfunction

  always @(posedge clk_i) begin
    out_beat_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, value %h", out_data_o.value);
      end else begin
        exp_r = result_q.pop_front();
        if (exp_r.kind != out_data_o.kind || exp_r.group != out_data_o.group ||
            exp_r.row != out_data_o.row || exp_r.col != out_data_o.col ||
            exp_r.value != out_data_o.value || exp_r.overflow != out_data_o.overflow ||
            exp_r.energy_not_positive != out_data_o.energy_not_positive ||
            exp_r.run_end != out_data_o.run_end)
          note_mismatch(exp_r, out_data_o);
      end
    end
  end

  task automatic send_particle(input in_beat_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    take_particle(b);
  endtask

  task automatic write_target(input logic [30:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    target_mass = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_field(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(1, 1 << 22);
      default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  function automatic in_beat_t make_beat(input logic [31:0] e, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z,
                                         input bit grp, input bit fin);
    in_beat_t b;
    b.energy = e;
    b.mom_x = x;
    b.mom_y = y;
    b.mom_z = z;
    b.second_group = grp;
    b.final_particle = fin;
    return b;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    in_beat_t b;
    int mode;
    localparam logic [31:0] ONE = 32'h00010000;
    localparam logic [31:0] PMAX = 32'h7fffffff;
    localparam logic [31:0] NMIN = 32'h80000000;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    target_mass = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    for (int i = 0; i < 8; i++) sums[i] = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // rows with typed values assume target 0
    rows.push_back('{make_beat(0, 0, 0, 0, 0, 1), 1, 32'sd0, 1});
    rows.push_back('{make_beat(ONE, 0, 0, 0, 0, 1), 1, 32'sd65536, 1});
    rows.push_back('{make_beat(ONE, 0, 0, 0, 1, 1), 1, -32'sd65536, 1});
    rows.push_back('{make_beat(ONE, 0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_beat(ONE, 0, 0, 0, 1, 1), 1, 32'sd0, 0});
    rows.push_back('{make_beat(PMAX, PMAX, PMAX, PMAX, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(NMIN, NMIN, NMIN, NMIN, 1, 1), 0, 0, 0});
    rows.push_back('{make_beat(PMAX, 0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_beat(PMAX, 0, 0, 0, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(NMIN, 0, 0, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_beat(NMIN, 0, 0, 0, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(ONE, 3 * ONE, 0, 0, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(5 * ONE, 0, 4 * ONE, 0, 0, 0), 0, 0, 0});
    rows.push_back('{make_beat(2 * ONE, 0, 0, -ONE, 1, 1), 0, 0, 0});
    rows.push_back('{make_beat(-ONE, ONE, -ONE, ONE, 1, 0), 0, 0, 0});
    rows.push_back('{make_beat(7 * ONE, -ONE, 2 * ONE, 3 * ONE, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(ONE, ONE, 0, 0, 0, 1), 0, 0, 0});
    rows.push_back('{make_beat(32'h40000000, 32'h3fff0000, 32'h100, -32'h100, 1, 1), 0, 0, 0});
    rows.push_back('{make_beat(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 0, 1),
                     0, 0, 0});
    rows.push_back('{make_beat(1, -1, 1, -1, 1, 1), 0, 0, 0});

    foreach (rows[i]) begin
      row = rows[i];
      send_particle(row.beat);
      if (row.has_exp && (last_constraint != row.exp_value || last_enp != row.exp_enp)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("constraint row %0d: expected %h enp %0d, predicted %h enp %0d", i,
                   row.exp_value, row.exp_enp, last_constraint, last_enp);
      end
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_target(31'h7fffffff);
        1: write_target(31'($urandom_range(0, 1 << 20)));
        2: write_target(31'($urandom()));
        default: write_target(31'h0);
      endcase
      send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 29 : 0;
      recv_stall_pct = (phase == 2) ? 79 : (phase == 3) ? 29 : 0;
      for (int n = 0; n < 53; n++) begin
        mode = ($urandom_range(9) < 2) ? 0 : $urandom_range(1, 2);
        b = make_beat(rand_field(mode), rand_field(mode == 1 ? 2 : mode),
                      rand_field(mode == 1 ? 2 : mode), rand_field(mode == 1 ? 2 : mode),
                      1'($urandom_range(1)), (n == 52) || ($urandom_range(3) == 0));
        send_particle(b);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
